[src/sspg_pkg.sv]
package sspg_pkg;

    localparam int NUM_CHANNELS_DEF  = 16;
    localparam int FRAME_PERIOD_RST  = 20000;
    localparam int CHANNEL_COUNT_RST = 16;

    localparam int PIN_W     = 16;
    localparam int CHAN_W    = 4;
    localparam int WIDTH_W   = 16;
    localparam int CURCH_W   = 5;
    localparam int PERIOD_W  = 16;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } sspg_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_PERIOD  = 2'd0,
        REG_CHANNEL_COUNT = 2'd1
    } sspg_reg_t;

    typedef struct packed {
        logic [0:0]         operation;
        logic [CHAN_W-1:0]  channel;
        logic [WIDTH_W-1:0] width;
    } sspg_in_t;

    typedef struct packed {
        logic [PIN_W-1:0]   pin_levels;
        logic [CURCH_W-1:0] current_channel;
        logic [0:0]         frame_start;
    } sspg_out_t;

endpackage

[src/sequential_servo_pulse_generator.sv]
// Servo pulse sequencer. Each input beat is either a timer tick or a pulse width
// write for one channel; every beat yields exactly one result beat carrying the
// pin levels, the channel being served and a frame-start flag. Channels are
// served one after another: a tick either counts down or ends the running pulse,
// skips an inactive channel, starts a pulse, or, once the frame period has elapsed
// while waiting, begins a new frame at channel 0. All the work for a beat is done
// in a single pass from the state registers to the result register, so one beat is
// taken every clock cycle; the block only stalls its input when the result
// register is full and the downstream side is not ready. Configuration writes
// (frame period, channel count) are taken at any time and should be issued while
// the block is idle.
module sequential_servo_pulse_generator
    import sspg_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sspg_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sspg_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Only channels reachable by the 4-bit write field can hold a width;
    // the rest always read as inactive.
    localparam int TABLE_DEPTH = (NUM_CHANNELS < (1 << CHAN_W)) ? NUM_CHANNELS : (1 << CHAN_W);
    localparam int TBL_IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CH_IDX_W    = $clog2(NUM_CHANNELS + 1);
    localparam int CMP_W       = (CH_IDX_W > COUNT_W) ? CH_IDX_W : COUNT_W;

    logic [WIDTH_W-1:0]  width_table_reg [TABLE_DEPTH];
    logic [CH_IDX_W-1:0] chan_idx_reg,     chan_idx_next;
    logic                pulse_active_reg, pulse_active_next;
    logic [WIDTH_W-1:0]  pulse_rem_reg,    pulse_rem_next;
    logic [PERIOD_W-1:0] elapsed_reg,      elapsed_next;
    logic [PERIOD_W-1:0] frame_period_reg;
    logic [COUNT_W-1:0]  channel_count_reg;
    logic                m_valid_reg;
    sspg_out_t           out_reg,          out_next;

    logic                s_accept;
    logic                frame_start;
    logic [CMP_W-1:0]    active_count;
    logic [CMP_W-1:0]    idx_inc;
    logic [CH_IDX_W-1:0] idx_adv;
    logic [WIDTH_W-1:0]  cur_width;
    logic [PERIOD_W-1:0] elapsed_inc;
    logic [CH_IDX_W+CURCH_W-1:0] idx_wide;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        active_count = (CMP_W'(channel_count_reg) > CMP_W'(NUM_CHANNELS))
                       ? CMP_W'(NUM_CHANNELS) : CMP_W'(channel_count_reg);

        idx_inc = (CMP_W'(chan_idx_reg) < CMP_W'(NUM_CHANNELS))
                  ? CMP_W'(chan_idx_reg) + CMP_W'(1) : CMP_W'(chan_idx_reg);
        idx_adv = (idx_inc >= active_count) ? CH_IDX_W'(NUM_CHANNELS) : idx_inc[CH_IDX_W-1:0];

        if (CMP_W'(chan_idx_reg) < CMP_W'(TABLE_DEPTH)) begin
            cur_width = width_table_reg[chan_idx_reg[TBL_IDX_W-1:0]];
        end else begin
            cur_width = '0;
        end

        elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + PERIOD_W'(1) : elapsed_reg;
    end

    always_comb begin
        chan_idx_next     = chan_idx_reg;
        pulse_active_next = pulse_active_reg;
        pulse_rem_next    = pulse_rem_reg;
        elapsed_next      = elapsed_reg;
        frame_start       = 1'b0;

        if (s_data.operation == OP_TICK) begin
            elapsed_next = elapsed_inc;
            if (pulse_active_reg) begin
                if (pulse_rem_reg == '0) begin
                    pulse_active_next = 1'b0;
                    chan_idx_next     = idx_adv;
                end else begin
                    pulse_rem_next = pulse_rem_reg - WIDTH_W'(1);
                end
            end else if (CMP_W'(chan_idx_reg) < active_count) begin
                if (cur_width == '0) begin
                    chan_idx_next = idx_adv;
                end else begin
                    pulse_active_next = 1'b1;
                    pulse_rem_next    = cur_width - WIDTH_W'(1);
                end
            end else if (elapsed_inc >= frame_period_reg) begin
                elapsed_next  = '0;
                frame_start   = 1'b1;
                chan_idx_next = (active_count != '0) ? '0 : CH_IDX_W'(NUM_CHANNELS);
            end
        end

        // The result reflects the state after this beat has been applied.
        for (int i = 0; i < PIN_W; i++) begin
            out_next.pin_levels[i] = pulse_active_next
                                     && (CMP_W'(chan_idx_next) == CMP_W'(i));
        end
        if (pulse_active_next || (CMP_W'(chan_idx_next) < active_count)) begin
            idx_wide = {{CURCH_W{1'b0}}, chan_idx_next};
        end else begin
            idx_wide = (CH_IDX_W + CURCH_W)'(NUM_CHANNELS);
        end
        out_next.current_channel = idx_wide[CURCH_W-1:0];
        out_next.frame_start     = frame_start;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_idx_reg      <= CH_IDX_W'(NUM_CHANNELS);
            pulse_active_reg  <= 1'b0;
            pulse_rem_reg     <= '0;
            elapsed_reg       <= '0;
            frame_period_reg  <= PERIOD_W'(FRAME_PERIOD_RST);
            channel_count_reg <= COUNT_W'(CHANNEL_COUNT_RST);
            m_valid_reg       <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                width_table_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_FRAME_PERIOD:  frame_period_reg  <= cfg_data[PERIOD_W-1:0];
                    REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                chan_idx_reg     <= chan_idx_next;
                pulse_active_reg <= pulse_active_next;
                pulse_rem_reg    <= pulse_rem_next;
                elapsed_reg      <= elapsed_next;
                if (s_data.operation == OP_WRITE
                    && ({1'b0, s_data.channel} < (CHAN_W + 1)'(TABLE_DEPTH))) begin
                    width_table_reg[s_data.channel[TBL_IDX_W-1:0]] <= s_data.width;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_levels_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot0(out_reg.pin_levels))
        else $error("more than one pin high at once");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while result register is full");

    a_frame_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.frame_start) |-> (out_reg.pin_levels == '0))
        else $error("pulse running on a frame-start beat");

    a_pulse_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pulse_active_reg |-> (CMP_W'(chan_idx_reg) < CMP_W'(NUM_CHANNELS)))
        else $error("pulse active with no channel selected");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import sspg_pkg::*;

    localparam int NCH         = NUM_CHANNELS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 150;
    localparam int MAX_REPORTS = 60;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    sspg_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    sspg_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Servo sequencer state as the testbench sees it.
    logic [WIDTH_W-1:0]  width_tbl [NCH];
    int                  chan_sel;
    bit                  pulse_on;
    logic [WIDTH_W-1:0]  pulse_left;
    logic [15:0]         frame_ticks;
    logic [PERIOD_W-1:0] period_reg;
    logic [COUNT_W-1:0]  count_reg;

    sspg_out_t due_outputs [$];
    sspg_out_t last_pred;

    int errors        = 0;
    int reports       = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;

    always #5 aclk = ~aclk;

    sequential_servo_pulse_generator #(
        .NUM_CHANNELS(NCH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    function automatic int served();
        return (count_reg > NCH) ? NCH : int'(count_reg);
    endfunction

    function automatic void move_on();
        if (chan_sel < NCH) chan_sel++;
        if (chan_sel >= served()) chan_sel = NCH;
    endfunction

    function automatic sspg_out_t servo_step(input sspg_in_t item);
        sspg_out_t res;
        bit        fstart;
        fstart = 1'b0;
        if (item.operation == OP_WRITE) begin
            if (int'(item.channel) < NCH) width_tbl[item.channel] = item.width;
        end else begin
            if (frame_ticks != 16'hFFFF) frame_ticks++;
            if (pulse_on) begin
                if (pulse_left == 0) begin
                    pulse_on = 1'b0;
                    move_on();
                end else begin
                    pulse_left--;
                end
            end else if (chan_sel < served()) begin
                if (width_tbl[chan_sel] == 0) begin
                    move_on();
                end else begin
                    pulse_on   = 1'b1;
                    pulse_left = width_tbl[chan_sel] - 1'b1;
                end
            end else if (frame_ticks >= period_reg) begin
                frame_ticks = '0;
                fstart      = 1'b1;
                chan_sel    = (served() > 0) ? 0 : NCH;
            end
        end
        res.pin_levels      = (pulse_on && chan_sel < PIN_W) ? (PIN_W'(1) << chan_sel) : '0;
        res.current_channel = (pulse_on || chan_sel < served()) ?
                              CURCH_W'(chan_sel) : CURCH_W'(NCH);
        res.frame_start     = fstart;
        return res;
    endfunction

    function automatic sspg_in_t random_item();
        sspg_in_t item;
        int       pick;
        item.channel = CHAN_W'($urandom_range(0, NCH - 1));
        item.width   = WIDTH_W'($urandom_range(0, 65535));
        if ($urandom_range(99) < 70) begin
            item.operation = OP_TICK;
            return item;
        end
        item.operation = OP_WRITE;
        pick = $urandom_range(99);
        // Wide pulses only go to channels that are not being served, so that
        // the frames keep turning over.
        if (pick < 10)
            item.width = '0;
        else if (pick < 70)
            item.width = WIDTH_W'($urandom_range(1, 4));
        else if (pick < 93 || int'(item.channel) < served())
            item.width = WIDTH_W'($urandom_range(5, 12));
        return item;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        errors++;
        if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    task automatic send_beat(input sspg_in_t item);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_pred = servo_step(item);
        due_outputs.push_back(last_pred);
    endtask

    task automatic tick(input int n);
        sspg_in_t item;
        repeat (n) begin
            item           = random_item();
            item.operation = OP_TICK;
            send_beat(item);
        end
    endtask

    task automatic tick_until_frame();
        do tick(1); while (!last_pred.frame_start);
    endtask

    task automatic put_width(input int ch, input logic [WIDTH_W-1:0] w);
        sspg_in_t item;
        item.operation = OP_WRITE;
        item.channel   = CHAN_W'(ch);
        item.width     = w;
        send_beat(item);
    endtask

    task automatic drain_outputs();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_outputs.size() != 0) @(posedge aclk);
    endtask

    task automatic write_config(input logic [15:0] period, input logic [15:0] count_word);
        drain_outputs();
        cfg_valid <= 1'b1;
        cfg_index <= REG_FRAME_PERIOD;
        cfg_data  <= period;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        period_reg = period;
        cfg_index <= REG_CHANNEL_COUNT;
        cfg_data  <= count_word;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        count_reg = count_word[COUNT_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic shuffle_config();
        int          pick;
        logic [15:0] period;
        logic [15:0] count_word;
        pick = $urandom_range(99);
        if (pick < 8)
            period = 16'(pick % 2);
        else if (pick < 14)
            period = 16'($urandom_range(0, 65535));
        else
            period = 16'($urandom_range(2, 50));
        pick = $urandom_range(99);
        if (pick < 10)
            count_word = '0;
        else if (pick < 22)
            count_word = 16'(NCH);
        else if (pick < 32)
            count_word = 16'($urandom_range(NCH + 1, 31));
        else
            count_word = 16'($urandom_range(1, NCH - 1));
        if ($urandom_range(3) == 0)
            count_word[15:COUNT_W] = (16 - COUNT_W)'($urandom_range(0, 2047));
        write_config(period, count_word);
        // A raised count may bring a wide channel into the frame; shorten it.
        for (int ch = 0; ch < served(); ch++) begin
            if (width_tbl[ch] > 64) put_width(ch, WIDTH_W'($urandom_range(1, 6)));
        end
    endtask

    task automatic test_first_frame();
        put_width(0, 2);
        put_width(2, 1);
        tick(4);
        write_config(6, 16'(CHANNEL_COUNT_RST));
        tick_until_frame();
        tick(24);
    endtask

    task automatic test_write_extremes();
        write_config(3, 4);
        put_width(0, 3);
        put_width(1, 0);
        put_width(2, 1);
        put_width(3, 2);
        put_width(15, 16'hFFFF);
        tick_until_frame();
        tick(1);
        // Clearing the width must not cut short the pulse already running.
        put_width(0, 16'h0000);
        tick(14);
    endtask

    task automatic test_count_zero();
        write_config(0, 0);
        tick(3);
        put_width(7, 5);
        tick(3);
    endtask

    task automatic test_count_over();
        put_width(15, 1);
        write_config(2, 31);
        tick(45);
    endtask

    task automatic test_count_lowered();
        write_config(5, 8);
        put_width(5, 6);
        put_width(6, 1);
        put_width(7, 1);
        do tick(1); while (!(pulse_on && chan_sel == 5));
        write_config(5, 3);
        tick(14);
    endtask

    task automatic test_backpressure();
        write_config(10, 4);
        hold_req = 1'b1;
        repeat (40) send_beat(random_item());
        drain_outputs();
        tick(10);
    endtask

    task automatic test_long_frame();
        // A pulse longer than the frame period: the next frame has to follow
        // straight after it.
        write_config(40, 1);
        put_width(0, 60);
        tick_until_frame();
        tick_until_frame();
        tick(4);
        put_width(0, 3);
    endtask

    task automatic test_random_traffic(input int items, input int send_pct,
                                       input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < items; i++) begin
            if (i % 120 == 0) shuffle_config();
            send_beat(random_item());
        end
        drain_outputs();
    endtask

    always @(posedge aclk) begin : drive_ready
        int hold_left;
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_outputs
        sspg_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_outputs.size() == 0) begin
                flag_mismatch("unexpected beat", '0, 32'(m_data));
            end else begin
                want = due_outputs.pop_front();
                if (m_data.pin_levels !== want.pin_levels)
                    flag_mismatch("pin_levels", 32'(want.pin_levels),
                                  32'(m_data.pin_levels));
                if (m_data.current_channel !== want.current_channel)
                    flag_mismatch("current_channel", 32'(want.current_channel),
                                  32'(m_data.current_channel));
                if (m_data.frame_start !== want.frame_start)
                    flag_mismatch("frame_start", 32'(want.frame_start),
                                  32'(m_data.frame_start));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : main
        for (int ch = 0; ch < NCH; ch++) width_tbl[ch] = '0;
        chan_sel    = NCH;
        pulse_on    = 1'b0;
        pulse_left  = '0;
        frame_ticks = '0;
        period_reg  = PERIOD_W'(FRAME_PERIOD_RST);
        count_reg   = COUNT_W'(CHANNEL_COUNT_RST);
        last_pred   = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_frame();
        test_write_extremes();
        test_count_zero();
        test_count_over();
        test_count_lowered();
        test_backpressure();
        test_long_frame();
        test_random_traffic(480, 8, 83);
        test_random_traffic(480, 83, 8);
        test_random_traffic(480, 0, 0);

        drain_outputs();
        repeat (10) @(posedge aclk);
        if (errors == 0 && due_outputs.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sequential_servo_pulse_generator.f]
src/sspg_pkg.sv
src/sequential_servo_pulse_generator.sv
sim/testbench.sv
